[sv/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants for the go-to-goal controller
// Widths, CORDIC angle table and the cell transfer bundle.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CORDIC_STAGES = 16;

  // datapath widths
  localparam int XY_W = 36;  // CORDIC x/y, covers gain growth of a 33 bit offset
  localparam int Z_W  = 34;  // Q2.30 angle with headroom
  localparam int SH_W = 5;   // shift amount of one cell

  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic signed [Z_W-1:0] HALF_PI = 34'sd1686629713;

  // register indexes
  localparam logic [2:0] REG_GOAL_X   = 3'd0;
  localparam logic [2:0] REG_GOAL_Y   = 3'd1;
  localparam logic [2:0] REG_LIN_GAIN = 3'd2;
  localparam logic [2:0] REG_ANG_GAIN = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;

  // one item moving down the cell chain
  typedef struct packed {
    logic                   vld;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [31:0]     hd;
    logic                   zero;
  } cell_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [SH_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

[sv/gtg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// gtg_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the x axis by atan(2^-shift) and registers the item.
// ----------------------------------------------------------------------------
module gtg_cordic_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [gtg_pkg::SH_W-1:0]        shift,
  input  logic signed [gtg_pkg::Z_W-1:0]  angle,
  input  gtg_pkg::cell_t                  din,
  output gtg_pkg::cell_t                  dout
);

  logic signed [gtg_pkg::XY_W-1:0] xs;
  logic signed [gtg_pkg::XY_W-1:0] ys;
  gtg_pkg::cell_t                  dout_next;

  // micro-rotation, direction from the sign of y
  always_comb begin
    xs = din.x >>> shift;
    ys = din.y >>> shift;
    dout_next = din;
    if (!din.y[gtg_pkg::XY_W-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + angle;
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[sv/gtg_scale.sv]
// ----------------------------------------------------------------------------
// gtg_scale: distance scaling, gains, arrival test and saturation
// Four registered stages after the CORDIC chain; the last is the output.
// ----------------------------------------------------------------------------
module gtg_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  gtg_pkg::cell_t     din,
  input  logic [15:0]        lin_gain,
  input  logic [15:0]        ang_gain,
  input  logic [30:0]        tol,
  output logic               out_vld,
  output logic signed [31:0] lin_vel,
  output logic signed [31:0] ang_vel,
  output logic               arr
);

  // stage M: split 1/K product
  logic               m_vld;
  logic [50:0]        m_phi;
  logic [47:0]        m_plo;
  logic signed [gtg_pkg::Z_W-1:0] m_z;
  logic signed [31:0] m_hd;
  logic               m_zero;
  logic [34:0]        xu;

  // stage D: distance and heading error
  logic               d_vld;
  logic [34:0]        d_dist;
  logic signed [46:0] d_err;
  logic [51:0]        dsum;
  logic signed [gtg_pkg::Z_W-1:0] zsel;

  // stage P: gain products
  logic               p_vld;
  logic [50:0]        p_lin;
  logic signed [63:0] p_ang;
  logic               p_arr;

  // output stage
  logic [42:0]        lin_sh;
  logic signed [41:0] ang_sh;
  logic signed [31:0] lin_next;
  logic signed [31:0] ang_next;

  assign xu   = din.x[gtg_pkg::XY_W-1] || (din.x == '0) ? 35'd0 : din.x[34:0];
  assign dsum = 52'(m_phi) + 52'(m_plo[47:16]);
  assign zsel = m_zero ? '0 : m_z;

  // saturation
  always_comb begin
    lin_sh = p_lin[50:8];
    ang_sh = 42'(p_ang >>> 22);
    if (lin_sh > 43'h0007FFFFFFF) lin_next = 32'sh7FFFFFFF;
    else                          lin_next = $signed(lin_sh[31:0]);
    if (ang_sh > 42'sh0007FFFFFFF)       ang_next = 32'sh7FFFFFFF;
    else if (ang_sh < -42'sh00080000000) ang_next = 32'sh80000000;
    else                                 ang_next = ang_sh[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld   <= 1'b0;
      d_vld   <= 1'b0;
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      m_vld   <= din.vld;
      d_vld   <= m_vld;
      p_vld   <= d_vld;
      out_vld <= p_vld;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      m_phi  <= 51'(xu[34:16]) * 51'(gtg_pkg::INV_GAIN);
      m_plo  <= 48'(xu[15:0]) * 48'(gtg_pkg::INV_GAIN);
      m_z    <= din.z;
      m_hd   <= din.hd;
      m_zero <= din.zero;
      d_dist <= dsum[50:16];
      d_err  <= 47'(zsel) - (47'(m_hd) <<< 14);
      p_lin  <= 51'(lin_gain) * 51'(d_dist);
      p_ang  <= 64'($signed({1'b0, ang_gain})) * 64'(d_err);
      p_arr  <= d_dist < 35'(tol);
      arr     <= p_arr;
      lin_vel <= p_arr ? 32'sd0 : lin_next;
      ang_vel <= p_arr ? 32'sd0 : ang_next;
    end
  end

endmodule

[sv/go_to_goal_controller.sv]
// ----------------------------------------------------------------------------
// go_to_goal_controller: proportional go-to-goal velocity controller
// Pose in, linear/angular velocity out, through a pipelined CORDIC chain.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  pose in  | in_valid / in_stall  | pose_x, pose_y, pose_heading
//  cmd out  | out_valid/ out_stall | linear_velocity, angular_velocity, arrived
//  config   | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One pose per cycle while the output is not stalled; a pose passes the
// pre-rotation register, one cell per CORDIC stage and four scaling stages
// ending at the output register. The whole pipeline holds while a result
// sits stalled at the output. Synchronous reset clears valid state and loads
// register defaults. cfg_ready is always high.
module go_to_goal_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic signed [31:0] pose_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  output logic               arrived,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic [15:0]        linear_gain;
  logic [15:0]        angular_gain;
  logic [30:0]        arrive_tolerance;

  logic                             en;
  logic signed [32:0]               dx;
  logic signed [32:0]               dy;
  gtg_pkg::cell_t                   pre_next;
  gtg_pkg::cell_t                   chain [0:gtg_pkg::CORDIC_STAGES];

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x           <= '0;
      goal_y           <= '0;
      linear_gain      <= 16'd384;
      angular_gain     <= 16'd1536;
      arrive_tolerance <= 31'd39322;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gtg_pkg::REG_GOAL_X:   goal_x           <= $signed(cfg_data);
        gtg_pkg::REG_GOAL_Y:   goal_y           <= $signed(cfg_data);
        gtg_pkg::REG_LIN_GAIN: linear_gain      <= cfg_data[15:0];
        gtg_pkg::REG_ANG_GAIN: angular_gain     <= cfg_data[15:0];
        gtg_pkg::REG_TOL:      arrive_tolerance <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // goal offset and quadrant pre-rotation
  always_comb begin
    dx = 33'(goal_x) - 33'(pose_x);
    dy = 33'(goal_y) - 33'(pose_y);
    pre_next.vld  = in_valid;
    pre_next.hd   = pose_heading;
    pre_next.zero = (dx == '0) && (dy == '0);
    pre_next.x    = 36'(dx);
    pre_next.y    = 36'(dy);
    pre_next.z    = '0;
    if (dx[32]) begin
      if (!dy[32]) begin
        pre_next.x = 36'(dy);
        pre_next.y = -36'(dx);
        pre_next.z = gtg_pkg::HALF_PI;
      end else begin
        pre_next.x = -36'(dy);
        pre_next.y = 36'(dx);
        pre_next.z = -gtg_pkg::HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0] <= pre_next;
    end
  end

  // CORDIC cell chain
  for (genvar g = 0; g < gtg_pkg::CORDIC_STAGES; g++) begin : g_cell
    gtg_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (gtg_pkg::SH_W'(g)),
      .angle (gtg_pkg::atan_q30(gtg_pkg::SH_W'(g))),
      .din   (chain[g]),
      .dout  (chain[g+1])
    );
  end

  gtg_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .din      (chain[gtg_pkg::CORDIC_STAGES]),
    .lin_gain (linear_gain),
    .ang_gain (angular_gain),
    .tol      (arrive_tolerance),
    .out_vld  (out_valid),
    .lin_vel  (linear_velocity),
    .ang_vel  (angular_velocity),
    .arr      (arrived)
  );

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> chain[0].vld)
    else $error("accepted pose did not enter the pipeline");
  a_hold_output: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(linear_velocity) &&
    $stable(angular_velocity))
    else $error("stalled result changed");
  a_arrived_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && arrived |-> linear_velocity == 32'sd0 && angular_velocity == 32'sd0)
    else $error("arrived with nonzero command");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
`endif

endmodule
